/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define PRPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define PRPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/prpt_pkg.sv */
// ----------------------------------------------------------------------------
// prpt_pkg
// Types and constants of the polymetric rhythm phase tracker.
// ----------------------------------------------------------------------------
package prpt_pkg;

  // Field widths
  localparam int CMD_W    = 1;
  localparam int TEMPO_W  = 13;
  localparam int TIME_W   = 32;
  localparam int KIND_W   = 2;
  localparam int PH16_W   = 16;
  localparam int PH19_W   = 19;
  localparam int BARS_W   = 4;
  localparam int NUMER_W  = 5;
  localparam int SWING_W  = 16;
  localparam int PERIOD_W = 26;

  // Configuration port
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int REGIDX_W = 2;

  localparam logic [REGIDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [REGIDX_W-1:0] REG_BARS   = 2'd1;
  localparam logic [REGIDX_W-1:0] REG_NUMER  = 2'd2;
  localparam logic [REGIDX_W-1:0] REG_SWING  = 2'd3;

  localparam logic                ENABLE_RST = 1'b1;
  localparam logic [BARS_W-1:0]   BARS_RST   = 4'd2;
  localparam logic [NUMER_W-1:0]  NUMER_RST  = 5'd7;
  localparam logic [SWING_W-1:0]  SWING_RST  = 16'd0;

  // Commands and event kinds
  localparam logic [CMD_W-1:0]  CMD_BEAT = 1'b0;
  localparam logic [CMD_W-1:0]  CMD_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_BEAT       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUB        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL_START = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FILL_END   = 2'd3;

  // Arithmetic constants
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 26'h3FF_FFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 26'd500000;
  localparam logic [PH19_W-1:0]   FILL_ENTER = 19'd39322;
  localparam logic [PH19_W-1:0]   FILL_LEAVE = 19'd13107;
  localparam int                  INC_FRAC_W = 14;   // numerator * 16384

  // Serial divider
  localparam int DVND_W = 30;
  localparam int REM_W  = PERIOD_W;
  localparam int DVSR_W = PERIOD_W;
  localparam int STEP_W = 5;

  localparam logic [DVND_W-1:0] US_PER_MIN_X16 = 30'd960000000;
  localparam logic [STEP_W-1:0] STEPS_PERIOD   = 5'd30;
  localparam logic [STEP_W-1:0] STEPS_INC      = 5'd19;
  localparam logic [STEP_W-1:0] STEPS_PHASE    = 5'd16;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_INC,
    ST_PHASE,
    ST_EVAL,
    ST_EMIT
  } state_t;

endpackage

/* hw/rtl/prpt_div.sv */
// ----------------------------------------------------------------------------
// prpt_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prpt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prpt_pkg::div_req_t          req,
  input  logic [prpt_pkg::REM_W-1:0]  rem_init,
  input  logic [prpt_pkg::DVSR_W-1:0] dvsr,
  input  logic [prpt_pkg::DVND_W-1:0] dvnd,
  output logic                        done,
  output logic [prpt_pkg::DVND_W-1:0] quot
);
  import prpt_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DVSR_W-1:0] dvsr_r;
  logic [DVND_W-1:0] dvnd_r;
  logic [DVND_W-1:0] quot_r;

  logic [REM_W:0]    trial;
  logic [REM_W:0]    trial_sub;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial     = {rem_r, dvnd_r[DVND_W-1]};
    trial_sub = trial - {1'b0, dvsr_r};
    ge        = (trial >= {1'b0, dvsr_r});
    rem_nxt   = ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= rem_init;
      dvsr_r <= dvsr;
      dvnd_r <= dvnd;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      dvnd_r <= {dvnd_r[DVND_W-2:0], 1'b0};
      quot_r <= {quot_r[DVND_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* hw/rtl/polymetric_rhythm_phase_tracker.sv */
// ----------------------------------------------------------------------------
// polymetric_rhythm_phase_tracker
// Tracks a four-four beat phase and an overlay meter phase; reports beats,
// sixteenth subdivisions and fill start/end events.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in_     | sink      | in_valid / in_stall        | command, tempo, now_us
//  out_    | source    | out_valid / out_stall      | event_kind, beat_phase,
//          |           |                            | overlay_phase, swing_shift,
//          |           |                            | fill_density, last
//  config  | APB slave | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  A beat runs the period divide (960e6 / tempo) and then the overlay
//  increment divide, both on the shared one-bit-per-cycle divider. A tick
//  runs a 16-bit phase divide, or none when the elapsed time is already
//  past the period. Results wait in one output register for as long as
//  the sink holds out_stall.
//  Reset is synchronous and active low; it restores the config, state and
//  control registers, not the payload ones, and empties the output register.
//  A new item is taken once the last result of the previous one is in the
//  output register, even if that result is still stalled.
//
module polymetric_rhythm_phase_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [prpt_pkg::CMD_W-1:0]    in_command,
  input  logic [prpt_pkg::TEMPO_W-1:0]  in_tempo,
  input  logic [prpt_pkg::TIME_W-1:0]   in_now_us,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [prpt_pkg::KIND_W-1:0]   out_event_kind,
  output logic [prpt_pkg::PH16_W-1:0]   out_beat_phase,
  output logic [prpt_pkg::PH19_W-1:0]   out_overlay_phase,
  output logic [prpt_pkg::SWING_W-1:0]  out_swing_shift,
  output logic [prpt_pkg::PH19_W-1:0]   out_fill_density,
  output logic                          out_last,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prpt_pkg::PADDR_W-1:0]  paddr,
  input  logic [prpt_pkg::PDATA_W-1:0]  pwdata,
  output logic [prpt_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import prpt_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                enable_r;
  logic [BARS_W-1:0]   bars_r;
  logic [NUMER_W-1:0]  numer_r;
  logic [SWING_W-1:0]  swing_amt_r;

  logic                cfg_wr;
  logic [REGIDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= ENABLE_RST;
      bars_r      <= BARS_RST;
      numer_r     <= NUMER_RST;
      swing_amt_r <= SWING_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE: enable_r    <= pwdata[0];
        REG_BARS:   bars_r      <= pwdata[BARS_W-1:0];
        REG_NUMER:  numer_r     <= pwdata[NUMER_W-1:0];
        REG_SWING:  swing_amt_r <= pwdata[SWING_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, enable_r};
      REG_BARS:   prdata = {{(PDATA_W-BARS_W){1'b0}}, bars_r};
      REG_NUMER:  prdata = {{(PDATA_W-NUMER_W){1'b0}}, numer_r};
      REG_SWING:  prdata = {{(PDATA_W-SWING_W){1'b0}}, swing_amt_r};
    endcase
  end

  // --------------------------------------------------------------------------
  // Tracker state
  // --------------------------------------------------------------------------
  state_t              state_r, state_nxt;

  logic [PH16_W-1:0]   beat_phase_r;
  logic [PH19_W-1:0]   overlay_phase_r;
  logic [PH16_W-1:0]   prev_six_r;      // also the sixteenth phase at the last evaluation
  logic [TIME_W-1:0]   last_beat_r;
  logic [PERIOD_W-1:0] period_r;
  logic                in_fill_r;

  // Results waiting for the output register
  logic                pend_beat_r;
  logic                pend_sub_r;
  logic                pend_fill_r;
  logic [KIND_W-1:0]   fill_kind_r;
  logic [SWING_W-1:0]  sub_swing_r;
  logic [PH19_W-1:0]   density_r;

  // Output register
  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [PH16_W-1:0]   out_bp_r;
  logic [PH19_W-1:0]   out_ov_r;
  logic [SWING_W-1:0]  out_sw_r;
  logic [PH19_W-1:0]   out_den_r;
  logic                out_last_r;

  // --------------------------------------------------------------------------
  // Shared serial divider
  // --------------------------------------------------------------------------
  div_req_t            div_req;
  logic [REM_W-1:0]    div_rem_init;
  logic [DVSR_W-1:0]   div_dvsr;
  logic [DVND_W-1:0]   div_dvnd;
  logic                div_done;
  logic [DVND_W-1:0]   div_quot;

  prpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .rem_init (div_rem_init),
    .dvsr     (div_dvsr),
    .dvnd     (div_dvnd),
    .done     (div_done),
    .quot     (div_quot)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic                in_fire;
  logic                slot_free;
  logic [TIME_W-1:0]   elapsed;
  logic                elapsed_ge;
  logic [BARS_W-1:0]   bars_eff;
  logic [PERIOD_W-1:0] period_sat;
  logic [PH19_W:0]     ov_sum;
  logic [PH19_W:0]     ov_wrap;
  logic [PH19_W-1:0]   ov_new;
  logic [PH16_W-1:0]   six;
  logic                sub_hit;
  logic [PH19_W-1:0]   bp_ext;
  logic [PH19_W-1:0]   diff;
  logic                fill_enter;
  logic                fill_leave;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    // Tick: time since the last beat, modulo 2^32
    elapsed    = in_now_us - last_beat_r;
    elapsed_ge = (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period_r});

    // Zero bars behaves as one bar
    bars_eff   = (bars_r == '0) ? BARS_W'(1) : bars_r;

    // Saturate the period quotient; a zero tempo gives all ones here too
    period_sat = (div_quot[DVND_W-1:PERIOD_W] != '0) ? PERIOD_MAX
                                                     : div_quot[PERIOD_W-1:0];

    // Overlay advance: wrap once at 1.0, then clamp to the Q3.16 range
    ov_sum  = {1'b0, overlay_phase_r} + {1'b0, div_quot[PH19_W-1:0]};
    ov_wrap = (ov_sum[PH19_W:PH16_W] != '0)
              ? {ov_sum[PH19_W:PH16_W] - 1'b1, ov_sum[PH16_W-1:0]}
              : ov_sum;
    ov_new  = ov_wrap[PH19_W] ? {PH19_W{1'b1}} : ov_wrap[PH19_W-1:0];

    // Sixteenth phase is the fraction of four times the beat phase
    six     = {beat_phase_r[PH16_W-3:0], 2'b00};
    sub_hit = (six < prev_six_r);

    bp_ext  = {{(PH19_W-PH16_W){1'b0}}, beat_phase_r};
    diff    = (bp_ext > overlay_phase_r) ? (bp_ext - overlay_phase_r)
                                         : (overlay_phase_r - bp_ext);
    fill_enter = !in_fill_r && (diff >= FILL_ENTER);
    fill_leave =  in_fill_r && (diff <= FILL_LEAVE);
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state, divider requests and output loads
  // --------------------------------------------------------------------------
  logic                out_ld;
  logic [KIND_W-1:0]   out_kind_d;
  logic [SWING_W-1:0]  out_sw_d;
  logic [PH19_W-1:0]   out_den_d;
  logic                out_last_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    div_req.start = 1'b0;
    div_req.steps = STEPS_PHASE;
    div_rem_init  = '0;
    div_dvsr      = period_r;
    div_dvnd      = '0;
    out_ld        = 1'b0;
    out_kind_d    = KIND_BEAT;
    out_sw_d      = '0;
    out_den_d     = '0;
    out_last_d    = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        // A disabled block takes the transfer and drops it
        if (in_fire && enable_r) begin
          if (in_command == CMD_BEAT) begin
            div_req.start = 1'b1;
            div_req.steps = STEPS_PERIOD;
            div_dvsr      = {{(DVSR_W-TEMPO_W){1'b0}}, in_tempo};
            div_dvnd      = US_PER_MIN_X16;
            state_nxt     = ST_PERIOD;
          end else if (elapsed_ge) begin
            state_nxt = ST_EVAL;
          end else begin
            // elapsed < period, so the phase quotient fits 16 bits
            div_req.start = 1'b1;
            div_req.steps = STEPS_PHASE;
            div_rem_init  = elapsed[REM_W-1:0];
            div_dvsr      = period_r;
            state_nxt     = ST_PHASE;
          end
        end
      end
      ST_PERIOD: begin
        if (div_done) begin
          // Overlay increment: numerator * 16384 / bars
          div_req.start = 1'b1;
          div_req.steps = STEPS_INC;
          div_dvsr      = {{(DVSR_W-BARS_W){1'b0}}, bars_eff};
          div_dvnd      = {numer_r, {(DVND_W-NUMER_W){1'b0}}};
          state_nxt     = ST_INC;
        end
      end
      ST_INC: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_PHASE: begin
        if (div_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = (sub_hit || fill_enter || fill_leave) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_ld = 1'b1;
          priority if (pend_beat_r) begin
            out_kind_d = KIND_BEAT;
            state_nxt  = ST_IDLE;
          end else if (pend_sub_r) begin
            // Subdivision goes ahead of a fill event
            out_kind_d = KIND_SUB;
            out_sw_d   = sub_swing_r;
            out_last_d = !pend_fill_r;
            if (!pend_fill_r) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            out_kind_d = fill_kind_r;
            out_den_d  = density_r;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Tracker state updates
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_phase_r    <= '0;
      overlay_phase_r <= '0;
      prev_six_r      <= '0;
      last_beat_r     <= '0;
      period_r        <= PERIOD_RST;
      in_fill_r       <= 1'b0;
      pend_beat_r     <= 1'b0;
      pend_sub_r      <= 1'b0;
      pend_fill_r     <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && enable_r) begin
            if (in_command == CMD_BEAT) begin
              last_beat_r  <= in_now_us;
              beat_phase_r <= '0;
            end else if (elapsed_ge) begin
              beat_phase_r <= '0;
            end
          end
        end
        ST_PERIOD: begin
          if (div_done) begin
            period_r <= period_sat;
          end
        end
        ST_INC: begin
          if (div_done) begin
            overlay_phase_r <= ov_new;
            pend_beat_r     <= 1'b1;
          end
        end
        ST_PHASE: begin
          if (div_done) begin
            beat_phase_r <= div_quot[PH16_W-1:0];
          end
        end
        ST_EVAL: begin
          prev_six_r  <= six;
          pend_sub_r  <= sub_hit;
          pend_fill_r <= fill_enter || fill_leave;
          if (fill_enter) begin
            in_fill_r <= 1'b1;
          end else if (fill_leave) begin
            in_fill_r <= 1'b0;
          end
        end
        ST_EMIT: begin
          // Drop each pending result as it moves to the output register
          if (slot_free) begin
            priority if (pend_beat_r) begin
              pend_beat_r <= 1'b0;
            end else if (pend_sub_r) begin
              pend_sub_r <= 1'b0;
            end else begin
              pend_fill_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Pending result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_EVAL) begin
      // Odd quarter of the sixteenth phase gets the swing
      sub_swing_r <= six[PH16_W-2] ? swing_amt_r : '0;
      fill_kind_r <= fill_enter ? KIND_FILL_START : KIND_FILL_END;
      density_r   <= fill_enter ? diff : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the payload while stalled; load only into a free slot
  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_kind_r <= out_kind_d;
      out_bp_r   <= beat_phase_r;
      out_ov_r   <= overlay_phase_r;
      out_sw_r   <= out_sw_d;
      out_den_r  <= out_den_d;
      out_last_r <= out_last_d;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_beat_phase    = out_bp_r;
  assign out_overlay_phase = out_ov_r;
  assign out_swing_shift   = out_sw_r;
  assign out_fill_density  = out_den_r;
  assign out_last          = out_last_r;

endmodule

/* hw/rtl/prpt_chk.sv */
// ----------------------------------------------------------------------------
// prpt_chk
// Port-level checks of the polymetric rhythm phase tracker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prpt_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [prpt_pkg::KIND_W-1:0]   out_event_kind,
  input logic [prpt_pkg::PH16_W-1:0]   out_beat_phase,
  input logic [prpt_pkg::PH19_W-1:0]   out_overlay_phase,
  input logic [prpt_pkg::SWING_W-1:0]  out_swing_shift,
  input logic [prpt_pkg::PH19_W-1:0]   out_fill_density,
  input logic                          out_last
);
  import prpt_pkg::*;

  logic in_fire;
  logic out_fire;
  logic beat_ok;
  logic is_beat;
  logic [KIND_W+PH16_W+PH19_W+SWING_W+PH19_W:0] out_payload;

  assign in_fire     = in_valid && !in_stall;
  assign out_fire    = out_valid && !out_stall;
  assign out_payload = {out_event_kind, out_beat_phase, out_overlay_phase,
                        out_swing_shift, out_fill_density, out_last};
  assign is_beat     = out_valid && (out_event_kind == KIND_BEAT);
  assign beat_ok     = out_last && (out_beat_phase == '0) && (out_swing_shift == '0)
                       && (out_fill_density == '0);

  // A stalled result stays offered
  `PRPT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

  // A stalled result keeps its payload
  `PRPT_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_payload), "payload moved")

  // The second result of an item follows its first without a gap
  `PRPT_ASSERT_NXT(a_burst, out_fire && !out_last && !in_fire, out_valid, "gap in a burst")

  // A beat event is alone, at phase zero, with no swing and no density
  `PRPT_ASSERT_IMP(a_beat_evt, is_beat, beat_ok, "malformed beat event")

endmodule

bind polymetric_rhythm_phase_tracker prpt_chk u_prpt_chk (.*);
